[rtl/csvq_pkg.sv]
// csvq_pkg: shared constants, types and control structs for the csv field quoter
// used by csvq_ctrl, csvq_dp, csv_row_field_quoter and csvq_checker; depends on nothing
`default_nettype none

package csvq_pkg;

	// field buffer size
	localparam int MAX_FIELD_LEN = 30;
	localparam int CNT_W         = $clog2(MAX_FIELD_LEN + 1);
	localparam int ADDR_W        = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1;
	localparam int BYTE_W        = 8;

	// special characters
	localparam logic [BYTE_W-1:0] CH_LF     = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'd34;
	localparam logic [BYTE_W-1:0] SEP_RESET = 8'd44;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPENQ,
		ST_READ,
		ST_BYTE,
		ST_DUPQ,
		ST_CLOSEQ,
		ST_TERM
	} state_t;

	// source of the next output beat
	typedef enum logic [1:0] {
		SEL_QUOTE,
		SEL_DATA,
		SEL_TERM
	} out_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     accept;
		logic     cfg_we;
		logic     clr_field;
		logic     idx_clr;
		logic     idx_inc;
		logic     rd_en;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_q;
		logic cnt_zero;
		logic idx_last;
		logic rd_is_quote;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

[rtl/csvq_ram.sv]
// csvq_ram: generic single-write, single-read ram with registered read data
// no package dependencies
`default_nettype none

module csvq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/csvq_ctrl.sv]
// csvq_ctrl: state machine that accepts field bytes and sequences the output burst
// depends on csvq_pkg for state, command and status types
`default_nettype none

module csvq_ctrl
	import csvq_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    end_of_field,
	input  wire logic    cfg_valid,
	input  wire status_t status,
	output logic         in_stall,
	output logic         cfg_ready,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;
	logic   idle;
	logic   in_acc;

	assign idle   = (state_q == ST_IDLE);
	assign in_acc = in_valid && idle;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && end_of_field) begin
					state_d = ST_OPENQ;
				end
			end
			ST_OPENQ: begin
				if (!status.needs_q || status.out_free) begin
					state_d = status.cnt_zero ? ST_CLOSEQ : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_BYTE;
			end
			ST_BYTE: begin
				if (status.out_free) begin
					if (status.needs_q && status.rd_is_quote) begin
						state_d = ST_DUPQ;
					end else begin
						state_d = status.idx_last ? ST_CLOSEQ : ST_READ;
					end
				end
			end
			ST_DUPQ: begin
				if (status.out_free) begin
					state_d = status.idx_last ? ST_CLOSEQ : ST_READ;
				end
			end
			ST_CLOSEQ: begin
				if (!status.needs_q || status.out_free) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd           = '0;
		cmd.out_sel   = SEL_QUOTE;
		cmd.accept    = in_acc;
		cmd.cfg_we    = cfg_valid && idle;
		in_stall      = !idle;
		cfg_ready     = idle;
		case (state_q)
			ST_IDLE: begin
				cmd.idx_clr = 1'b1;
			end
			ST_OPENQ: begin
				cmd.out_load = status.needs_q && status.out_free;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_BYTE: begin
				cmd.out_sel  = SEL_DATA;
				cmd.out_load = status.out_free;
				cmd.idx_inc  = status.out_free && !(status.needs_q && status.rd_is_quote);
			end
			ST_DUPQ: begin
				cmd.out_load = status.out_free;
				cmd.idx_inc  = status.out_free;
			end
			ST_CLOSEQ: begin
				cmd.out_load = status.needs_q && status.out_free;
			end
			ST_TERM: begin
				cmd.out_sel   = SEL_TERM;
				cmd.out_load  = status.out_free;
				cmd.clr_field = status.out_free;
			end
			default: begin
				cmd.idx_clr = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/csvq_dp.sv]
// csvq_dp: field buffer, quoting flags, separator register and output register
// depends on csvq_pkg and csvq_ram
`default_nettype none

module csvq_dp
	import csvq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              byte_valid,
	input  wire logic              end_of_row,
	input  wire logic [BYTE_W-1:0] cfg_data,
	input  wire logic              out_stall,
	output status_t                status,
	output logic                   out_valid,
	output logic      [BYTE_W-1:0] out_byte,
	output logic                   last,
	output logic                   overflow
);

	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] idx_q;
	logic              needs_q_q;
	logic              ovf_q;
	logic              eor_q;
	logic [BYTE_W-1:0] sep_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic              ovf_out_q;

	logic              full;
	logic              special;
	logic              store_we;
	logic [BYTE_W-1:0] rdata;
	logic [BYTE_W-1:0] next_byte;

	assign full     = (count_q == CNT_W'(MAX_FIELD_LEN));
	assign store_we = cmd.accept && byte_valid && !full;

	// bytes that force the field into quotes
	always_comb begin
		special = (data_byte == sep_q);
		if (data_byte inside {CH_LF, CH_CR, CH_QUOTE}) begin
			special = 1'b1;
		end
	end

	// field buffer
	csvq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_FIELD_LEN)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (data_byte),
		.re    (cmd.rd_en),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// fill count and field flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			needs_q_q <= 1'b0;
			ovf_q     <= 1'b0;
			eor_q     <= 1'b0;
		end else begin
			if (cmd.clr_field) begin
				count_q   <= '0;
				needs_q_q <= 1'b0;
				ovf_q     <= 1'b0;
			end else if (cmd.accept && byte_valid) begin
				if (!full) begin
					count_q <= count_q + CNT_W'(1);
					if (special) begin
						needs_q_q <= 1'b1;
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.accept) begin
				eor_q <= end_of_row;
			end
		end
	end

	// read index for the burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + ADDR_W'(1);
		end
	end

	// separator register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEP_RESET;
		end else if (cmd.cfg_we) begin
			sep_q <= cfg_data;
		end
	end

	// output beat source
	always_comb begin
		case (cmd.out_sel)
			SEL_QUOTE: next_byte = CH_QUOTE;
			SEL_DATA:  next_byte = rdata;
			SEL_TERM:  next_byte = eor_q ? CH_LF : sep_q;
			default:   next_byte = CH_QUOTE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_byte_q <= next_byte;
			last_q     <= (cmd.out_sel == SEL_TERM);
			ovf_out_q  <= ovf_q;
		end
	end

	// status to the controller
	assign status.needs_q     = needs_q_q;
	assign status.cnt_zero    = (count_q == '0);
	assign status.idx_last    = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign status.rd_is_quote = (rdata == CH_QUOTE);
	assign status.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign overflow  = ovf_out_q;

endmodule

`default_nettype wire

[rtl/csv_row_field_quoter.sv]
// csv_row_field_quoter: top level of the csv field quoter
// depends on csvq_pkg, csvq_ctrl and csvq_dp
`default_nettype none

// Quotes one CSV field at a time. Each input beat carries at most one byte of
// the current field; bytes are held in a 30-entry buffer (later bytes are
// dropped and flag overflow on the whole burst). A beat with end_of_field
// starts the output burst, during which in_stall stays high. The burst is
// driven from one ram read port: every stored byte is read, then loaded into
// the output register, and a quote in the field is doubled. A field that
// holds the separator, CR, LF or a quote gets an opening and a closing quote.
// The burst ends with the separator, or LF when end_of_row is set, marked by
// last. The separator register resets to a comma and is written only while
// idle.

module csv_row_field_quoter
	import csvq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              byte_valid,
	input  wire logic              end_of_field,
	input  wire logic              end_of_row,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [BYTE_W-1:0] out_byte,
	output logic                   last,
	output logic                   overflow,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [BYTE_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// sequencing
	csvq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.end_of_field (end_of_field),
		.cfg_valid    (cfg_valid),
		.status       (status),
		.in_stall     (in_stall),
		.cfg_ready    (cfg_ready),
		.cmd          (cmd)
	);

	// buffer and output path
	csvq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.end_of_row (end_of_row),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.status     (status),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.last       (last),
		.overflow   (overflow)
	);

endmodule

`default_nettype wire

[rtl/csvq_checker.sv]
// csvq_checker: port-level assertions for csv_row_field_quoter, bound to the top
// depends on csvq_pkg for the byte width
`default_nettype none

module csvq_checker
	import csvq_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              end_of_field,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [BYTE_W-1:0] out_byte,
	input wire logic              last
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("stalled output beat changed");

	// a field end starts a burst, so input stalls next
	a_eof_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_field |=> in_stall)
		else $error("input not stalled after field end");

	// stall only rises after a field end was taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && end_of_field))
		else $error("input stalled without a field end");

	// a burst is not finished before its last beat
	a_burst_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input open during an unfinished burst");

endmodule

bind csv_row_field_quoter csvq_checker u_csvq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.end_of_field (end_of_field),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_byte     (out_byte),
	.last         (last)
);

`default_nettype wire
